[hw/rtl/lru_key_cache_directory_core_assert.svh]
// Assertion helpers used by the directory control block.
`ifndef LRU_KEY_CACHE_DIRECTORY_CORE_ASSERT_SVH
`define LRU_KEY_CACHE_DIRECTORY_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LKCD_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lkcd assertion failed");

// Next-cycle implication, disabled during reset.
`define LKCD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lkcd assertion failed");

`endif

[hw/rtl/lkcd_pkg.sv]
package lkcd_pkg;

   // Fixed field widths
   localparam int LEN_BITS    = 20;
   localparam int STATUS_BITS = 2;
   localparam int SLOT_BITS   = 4;
   localparam int REQ_KEY_BITS = 64;

   // Parameter defaults
   localparam int DEF_ENTRIES    = 16;
   localparam int DEF_KEY_BITS   = 64;
   localparam int DEF_STAMP_BITS = 32;

   localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = 20'd102400;

   // Operation codes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   // Response status codes
   localparam logic [STATUS_BITS-1:0] STATUS_HIT    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_MISS   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_STORED = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_REJECT = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   // Flags carried cell to cell during a sweep
   typedef struct packed {
      logic active;
      logic found;
      logic have_inv;
   } sweep_flags_type;

   // Write-back command broadcast to the cells
   typedef struct packed {
      logic en;
      logic insert;
   } write_cmd_type;

endpackage

[hw/rtl/lru_key_cache_directory_core.sv]
// Fully associative key directory with least-recently-used replacement.
// Each request (lookup or insert) passes from acceptance to response as
// the sweep record moves down the chain of entry cells, registered in each
// cell (match, first free entry, least and largest use stamp), the record
// is captured at the end of the chain, and write-back updates the chosen
// entry and loads the response register. One request is in flight at a
// time; the next is accepted on the cycle after write-back, even while the
// previous response still waits to be taken. A response that is not taken
// holds the following request in write-back. Stamps reset to zero with
// the entries.
module lru_key_cache_directory_core import lkcd_pkg::*; #(
   parameter int ENTRIES    = DEF_ENTRIES,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int STAMP_BITS = DEF_STAMP_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_op,
   input  logic [REQ_KEY_BITS-1:0] req_lookup_key,
   input  logic [LEN_BITS-1:0]     req_obj_length,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_BITS-1:0]  rsp_status,
   output logic [SLOT_BITS-1:0]    rsp_slot,
   output logic [LEN_BITS-1:0]     rsp_stored_length,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [LEN_BITS-1:0]     csr_max_object_length
);

   localparam int IDX_BITS = $clog2(ENTRIES);

   // sweep links, index 0 feeds the first cell
   sweep_flags_type       flags_w     [ENTRIES+1];
   logic [IDX_BITS-1:0]   pos_w       [ENTRIES+1];
   logic [STAMP_BITS-1:0] max_w       [ENTRIES+1];
   logic [STAMP_BITS-1:0] least_w     [ENTRIES+1];
   logic [IDX_BITS-1:0]   least_idx_w [ENTRIES+1];
   logic [IDX_BITS-1:0]   found_idx_w [ENTRIES+1];
   logic [LEN_BITS-1:0]   found_len_w [ENTRIES+1];
   logic [IDX_BITS-1:0]   inv_idx_w   [ENTRIES+1];

   logic                  start;
   logic [KEY_BITS-1:0]   key;
   logic [ENTRIES-1:0]    wr_sel;
   write_cmd_type         wr_cmd;
   logic [LEN_BITS-1:0]   wr_len;
   logic [STAMP_BITS-1:0] wr_stamp;

   // initial sweep record
   assign flags_w[0]     = '{active: start, found: 1'b0, have_inv: 1'b0};
   assign pos_w[0]       = '0;
   assign max_w[0]       = '0;
   assign least_w[0]     = '1;
   assign least_idx_w[0] = '0;
   assign found_idx_w[0] = '0;
   assign found_len_w[0] = '0;
   assign inv_idx_w[0]   = '0;

   lkcd_ctrl #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .STAMP_BITS (STAMP_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_lookup_key        (req_lookup_key),
      .req_obj_length        (req_obj_length),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_slot              (rsp_slot),
      .rsp_stored_length     (rsp_stored_length),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_max_object_length (csr_max_object_length),
      .start                 (start),
      .key                   (key),
      .tail_flags            (flags_w[ENTRIES]),
      .tail_max              (max_w[ENTRIES]),
      .tail_least_idx        (least_idx_w[ENTRIES]),
      .tail_found_idx        (found_idx_w[ENTRIES]),
      .tail_found_len        (found_len_w[ENTRIES]),
      .tail_inv_idx          (inv_idx_w[ENTRIES]),
      .wr_sel                (wr_sel),
      .wr_cmd                (wr_cmd),
      .wr_len                (wr_len),
      .wr_stamp              (wr_stamp)
   );

   // chain of entry cells
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkcd_cell #(
         .KEY_BITS   (KEY_BITS),
         .STAMP_BITS (STAMP_BITS),
         .IDX_BITS   (IDX_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .flags_in      (flags_w[i]),
         .pos_in        (pos_w[i]),
         .max_in        (max_w[i]),
         .least_in      (least_w[i]),
         .least_idx_in  (least_idx_w[i]),
         .found_idx_in  (found_idx_w[i]),
         .found_len_in  (found_len_w[i]),
         .inv_idx_in    (inv_idx_w[i]),
         .key_in        (key),
         .flags_out     (flags_w[i+1]),
         .pos_out       (pos_w[i+1]),
         .max_out       (max_w[i+1]),
         .least_out     (least_w[i+1]),
         .least_idx_out (least_idx_w[i+1]),
         .found_idx_out (found_idx_w[i+1]),
         .found_len_out (found_len_w[i+1]),
         .inv_idx_out   (inv_idx_w[i+1]),
         .wr_sel        (wr_sel[i]),
         .wr_cmd        (wr_cmd),
         .wr_key        (key),
         .wr_len        (wr_len),
         .wr_stamp      (wr_stamp)
      );
   end

endmodule

[hw/rtl/lkcd_cell.sv]
module lkcd_cell import lkcd_pkg::*; #(
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int STAMP_BITS = DEF_STAMP_BITS,
   parameter int IDX_BITS   = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // sweep from the previous cell
   input  sweep_flags_type       flags_in,
   input  logic [IDX_BITS-1:0]   pos_in,
   input  logic [STAMP_BITS-1:0] max_in,
   input  logic [STAMP_BITS-1:0] least_in,
   input  logic [IDX_BITS-1:0]   least_idx_in,
   input  logic [IDX_BITS-1:0]   found_idx_in,
   input  logic [LEN_BITS-1:0]   found_len_in,
   input  logic [IDX_BITS-1:0]   inv_idx_in,
   input  logic [KEY_BITS-1:0]   key_in,
   // sweep to the next cell
   output sweep_flags_type       flags_out,
   output logic [IDX_BITS-1:0]   pos_out,
   output logic [STAMP_BITS-1:0] max_out,
   output logic [STAMP_BITS-1:0] least_out,
   output logic [IDX_BITS-1:0]   least_idx_out,
   output logic [IDX_BITS-1:0]   found_idx_out,
   output logic [LEN_BITS-1:0]   found_len_out,
   output logic [IDX_BITS-1:0]   inv_idx_out,
   // write-back
   input  logic                  wr_sel,
   input  write_cmd_type         wr_cmd,
   input  logic [KEY_BITS-1:0]   wr_key,
   input  logic [LEN_BITS-1:0]   wr_len,
   input  logic [STAMP_BITS-1:0] wr_stamp
);

   // entry state
   logic                  valid_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [LEN_BITS-1:0]   len_ff;
   logic [STAMP_BITS-1:0] stamp_ff;

   // sweep stage registers
   sweep_flags_type       flags_ff, flags_in_w;
   logic [IDX_BITS-1:0]   pos_ff, pos_in_w;
   logic [STAMP_BITS-1:0] max_ff, max_in_w;
   logic [STAMP_BITS-1:0] least_ff, least_in_w;
   logic [IDX_BITS-1:0]   least_idx_ff, least_idx_in_w;
   logic [IDX_BITS-1:0]   found_idx_ff, found_idx_in_w;
   logic [LEN_BITS-1:0]   found_len_ff, found_len_in_w;
   logic [IDX_BITS-1:0]   inv_idx_ff, inv_idx_in_w;

   logic match;

   // fold this entry into the running record
   always_comb begin
      match          = valid_ff && (key_ff == key_in);
      flags_in_w     = flags_in;
      pos_in_w       = IDX_BITS'(pos_in + 1'b1);
      max_in_w       = (stamp_ff > max_in) ? stamp_ff : max_in;
      least_in_w     = least_in;
      least_idx_in_w = least_idx_in;
      found_idx_in_w = found_idx_in;
      found_len_in_w = found_len_in;
      inv_idx_in_w   = inv_idx_in;
      // strict compare keeps the lowest index among equal stamps
      if (stamp_ff < least_in) begin
         least_in_w     = stamp_ff;
         least_idx_in_w = pos_in;
      end
      // first free entry wins
      if (!flags_in.have_inv && !valid_ff) begin
         flags_in_w.have_inv = 1'b1;
         inv_idx_in_w        = pos_in;
      end
      // last match wins, i.e. highest index
      if (match) begin
         flags_in_w.found = 1'b1;
         found_idx_in_w   = pos_in;
         found_len_in_w   = len_ff;
      end
   end

   // sweep stage
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in_w;
      end
      pos_ff       <= pos_in_w;
      max_ff       <= max_in_w;
      least_ff     <= least_in_w;
      least_idx_ff <= least_idx_in_w;
      found_idx_ff <= found_idx_in_w;
      found_len_ff <= found_len_in_w;
      inv_idx_ff   <= inv_idx_in_w;
   end

   // entry update on write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         stamp_ff <= '0;
      end else if (wr_cmd.en && wr_sel) begin
         stamp_ff <= wr_stamp;
         if (wr_cmd.insert) begin
            valid_ff <= 1'b1;
         end
      end
      if (wr_cmd.en && wr_sel && wr_cmd.insert) begin
         key_ff <= wr_key;
         len_ff <= wr_len;
      end
   end

   assign flags_out     = flags_ff;
   assign pos_out       = pos_ff;
   assign max_out       = max_ff;
   assign least_out     = least_ff;
   assign least_idx_out = least_idx_ff;
   assign found_idx_out = found_idx_ff;
   assign found_len_out = found_len_ff;
   assign inv_idx_out   = inv_idx_ff;

endmodule

[hw/rtl/lkcd_ctrl.sv]
`include "lru_key_cache_directory_core_assert.svh"

module lkcd_ctrl import lkcd_pkg::*; #(
   parameter int ENTRIES    = DEF_ENTRIES,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int STAMP_BITS = DEF_STAMP_BITS,
   parameter int IDX_BITS   = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_op,
   input  logic [REQ_KEY_BITS-1:0] req_lookup_key,
   input  logic [LEN_BITS-1:0]     req_obj_length,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_BITS-1:0]  rsp_status,
   output logic [SLOT_BITS-1:0]    rsp_slot,
   output logic [LEN_BITS-1:0]     rsp_stored_length,
   // configuration
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [LEN_BITS-1:0]     csr_max_object_length,
   // chain head
   output logic                    start,
   output logic [KEY_BITS-1:0]     key,
   // chain tail
   input  sweep_flags_type         tail_flags,
   input  logic [STAMP_BITS-1:0]   tail_max,
   input  logic [IDX_BITS-1:0]     tail_least_idx,
   input  logic [IDX_BITS-1:0]     tail_found_idx,
   input  logic [LEN_BITS-1:0]     tail_found_len,
   input  logic [IDX_BITS-1:0]     tail_inv_idx,
   // write-back
   output logic [ENTRIES-1:0]      wr_sel,
   output write_cmd_type           wr_cmd,
   output logic [LEN_BITS-1:0]     wr_len,
   output logic [STAMP_BITS-1:0]   wr_stamp
);

   state_type state_ff, state_in;

   logic                  start_ff;
   logic                  op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [LEN_BITS-1:0]   len_ff;
   logic [LEN_BITS-1:0]   max_len_ff;

   // captured sweep result
   sweep_flags_type       res_flags_ff;
   logic [STAMP_BITS-1:0] res_max_ff;
   logic [IDX_BITS-1:0]   res_least_idx_ff;
   logic [IDX_BITS-1:0]   res_found_idx_ff;
   logic [LEN_BITS-1:0]   res_found_len_ff;
   logic [IDX_BITS-1:0]   res_inv_idx_ff;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_BITS-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [LEN_BITS-1:0]    rsp_len_ff, rsp_len_in;

   logic                  req_take;
   logic                  rsp_free;
   logic                  finish;
   logic [IDX_BITS-1:0]   wr_idx;

   // no handshake while reset is held
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = !reset;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // next state, write-back and response
   always_comb begin
      state_in      = state_ff;
      finish        = 1'b0;
      wr_cmd        = '0;
      wr_idx        = '0;
      wr_stamp      = (res_max_ff == {STAMP_BITS{1'b1}}) ? res_max_ff
                                                          : STAMP_BITS'(res_max_ff + 1'b1);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_len_in    = rsp_len_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (tail_flags.active) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               finish        = 1'b1;
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = '0;
               rsp_len_in    = '0;
               if (op_ff == OP_LOOKUP) begin
                  if (res_flags_ff.found) begin
                     rsp_status_in = STATUS_HIT;
                     rsp_slot_in   = SLOT_BITS'(res_found_idx_ff);
                     rsp_len_in    = res_found_len_ff;
                     wr_cmd.en     = 1'b1;
                     wr_idx        = res_found_idx_ff;
                  end else begin
                     rsp_status_in = STATUS_MISS;
                  end
               end else if (len_ff > max_len_ff) begin
                  rsp_status_in = STATUS_REJECT;
               end else begin
                  wr_cmd.en     = 1'b1;
                  wr_cmd.insert = 1'b1;
                  wr_idx        = res_flags_ff.have_inv ? res_inv_idx_ff : res_least_idx_ff;
                  rsp_status_in = STATUS_STORED;
                  rsp_slot_in   = SLOT_BITS'(wr_idx);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // one-hot entry select
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         wr_sel[i] = wr_cmd.en && (wr_idx == IDX_BITS'(i));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_len_ff   <= MAX_LEN_RESET;
      end else begin
         state_ff     <= state_in;
         start_ff     <= req_take;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_max_object_length;
         end
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_op;
         key_ff <= req_lookup_key[KEY_BITS-1:0];
         len_ff <= req_obj_length;
      end
      if (state_ff == ST_SWEEP && tail_flags.active) begin
         res_flags_ff     <= tail_flags;
         res_max_ff       <= tail_max;
         res_least_idx_ff <= tail_least_idx;
         res_found_idx_ff <= tail_found_idx;
         res_found_len_ff <= tail_found_len;
         res_inv_idx_ff   <= tail_inv_idx;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign start             = start_ff;
   assign key               = key_ff;
   assign wr_len            = len_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_stored_length = rsp_len_ff;

   // an accepted request launches exactly one sweep
   `LKCD_ASSERT_NEXT(a_take_starts, clock, reset, req_take, start_ff && state_ff == ST_SWEEP)
   // the sweep result only arrives while a sweep is in flight
   `LKCD_ASSERT_NOW(a_tail_in_sweep, clock, reset, tail_flags.active, state_ff == ST_SWEEP)
   // a new response appears only after a finished request
   `LKCD_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
                    $past(state_ff) == ST_DONE)
   // entry updates only happen when a result is delivered
   `LKCD_ASSERT_NOW(a_write_on_finish, clock, reset, wr_cmd.en, finish && $onehot(wr_sel))

endmodule

[dv/lru_key_cache_directory_core_tb.sv]
module lru_key_cache_directory_core_tb import lkcd_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES        = DEF_ENTRIES;
   localparam int KEY_BITS       = DEF_KEY_BITS;
   localparam int STAMP_BITS     = DEF_STAMP_BITS;
   localparam int KEY_POOL_SIZE  = 24;
   localparam int PHASE_REQUESTS = 530;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = ENTRIES + 14;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [SLOT_BITS-1:0]   slot;
      logic [LEN_BITS-1:0]    length;
   } dir_response_type;

   // DUT connections
   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_op = OP_LOOKUP;
   logic [REQ_KEY_BITS-1:0] req_lookup_key = '0;
   logic [LEN_BITS-1:0]     req_obj_length = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic [SLOT_BITS-1:0]    rsp_slot;
   logic [LEN_BITS-1:0]     rsp_stored_length;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [LEN_BITS-1:0]     csr_max_object_length = '0;

   // Shadow copy of the directory
   logic                  dir_valid [ENTRIES];
   logic [KEY_BITS-1:0]   dir_key   [ENTRIES];
   logic [LEN_BITS-1:0]   dir_len   [ENTRIES];
   logic [STAMP_BITS-1:0] dir_stamp [ENTRIES];
   logic [LEN_BITS-1:0]   max_len_limit = MAX_LEN_RESET;

   dir_response_type pending_responses[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int error_count        = 0;
   int stall_cycles       = 0;
   int request_count      = 0;
   int hit_count          = 0;
   int miss_count         = 0;
   int store_count        = 0;
   int evict_count        = 0;
   int reject_count       = 0;
   int limit_writes       = 0;

   lru_key_cache_directory_core #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .STAMP_BITS(STAMP_BITS)
   ) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_lookup_key       (req_lookup_key),
      .req_obj_length       (req_obj_length),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_slot             (rsp_slot),
      .rsp_stored_length    (rsp_stored_length),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_object_length(csr_max_object_length)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         dir_valid[i] = 1'b0;
         dir_key[i]   = '0;
         dir_len[i]   = '0;
         dir_stamp[i] = '0;
      end
   end

   // Directory behavior: lookup refreshes the highest-index match, insert fills or evicts LRU
   function automatic dir_response_type predict_directory_access(
      input logic op, input logic [REQ_KEY_BITS-1:0] key, input logic [LEN_BITS-1:0] len);
      dir_response_type      r;
      logic [KEY_BITS-1:0]   k;
      logic [STAMP_BITS-1:0] top;
      logic [STAMP_BITS-1:0] fresh;
      int                    hit_idx;
      int                    target;
      int                    least;
      k = key[KEY_BITS-1:0];
      r.status = STATUS_MISS;
      r.slot   = '0;
      r.length = '0;
      // newest stamp spans every entry, valid or not; saturates at all ones
      top = '0;
      for (int i = 0; i < ENTRIES; i++)
         if (dir_stamp[i] > top) top = dir_stamp[i];
      fresh = (top == '1) ? top : top + 1'b1;
      if (op == OP_LOOKUP) begin
         hit_idx = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i] && dir_key[i] == k) hit_idx = i;
         if (hit_idx >= 0) begin
            dir_stamp[hit_idx] = fresh;
            r.status = STATUS_HIT;
            r.slot   = SLOT_BITS'(hit_idx);
            r.length = dir_len[hit_idx];
            hit_count++;
         end else begin
            miss_count++;
         end
      end else if (len > max_len_limit) begin
         r.status = STATUS_REJECT;
         reject_count++;
      end else begin
         target = -1;
         least  = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (target < 0 && !dir_valid[i]) target = i;
            if (dir_stamp[i] < dir_stamp[least]) least = i;
         end
         if (target < 0) begin
            target = least;
            evict_count++;
         end
         dir_valid[target] = 1'b1;
         dir_key[target]   = k;
         dir_len[target]   = len;
         dir_stamp[target] = fresh;
         r.status = STATUS_STORED;
         r.slot   = SLOT_BITS'(target);
         store_count++;
      end
      return r;
   endfunction

   // Response receiver with random back-pressure, and the checker
   always @(posedge clock) begin
      dir_response_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (pending_responses.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response status %0d slot %0d length %0d",
                        $time, rsp_status, rsp_slot, rsp_stored_length);
            end else begin
               want = pending_responses.pop_front();
               if (rsp_status !== want.status) begin
                  error_count++;
                  $display("%0t: rsp_status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_slot !== want.slot) begin
                  error_count++;
                  $display("%0t: rsp_slot expected %0d actual %0d",
                           $time, want.slot, rsp_slot);
               end
               if (rsp_stored_length !== want.length) begin
                  error_count++;
                  $display("%0t: rsp_stored_length expected %0d actual %0d",
                           $time, want.length, rsp_stored_length);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("lru_key_cache_directory_core verification failed");
            $finish;
         end
      end
   end

   task automatic apply_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   endtask

   // Send one request; valid stays up so back-to-back requests need no extra edge
   task automatic issue_request(input logic op, input logic [REQ_KEY_BITS-1:0] key,
                                input logic [LEN_BITS-1:0] len);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_lookup_key <= key;
      req_obj_length <= len;
      do @(posedge clock); while (!req_ready);
      pending_responses.push_back(predict_directory_access(op, key, len));
      request_count++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // Limit is only changed with the directory idle
   task automatic write_max_length(input logic [LEN_BITS-1:0] value);
      wait_for_drain();
      csr_valid             <= 1'b1;
      csr_max_object_length <= value;
      do @(posedge clock); while (!csr_ready);
      max_len_limit = value;
      limit_writes++;
      csr_valid <= 1'b0;
   endtask

   // Lookups into an empty directory all miss
   task automatic test_empty_lookups();
      issue_request(OP_LOOKUP, '0, '0);
      issue_request(OP_LOOKUP, '1, '1);
      issue_request(OP_LOOKUP, {$urandom, $urandom}, '0);
   endtask

   // Lengths around the reset limit; slot 0 must report a real hit
   task automatic test_length_boundaries();
      logic [REQ_KEY_BITS-1:0] key_a;
      logic [REQ_KEY_BITS-1:0] key_b;
      key_a = {$urandom, $urandom};
      key_b = ~key_a;
      issue_request(OP_INSERT, '0, '0);
      issue_request(OP_LOOKUP, '0, '1);
      issue_request(OP_INSERT, key_a, MAX_LEN_RESET);
      issue_request(OP_INSERT, key_b, MAX_LEN_RESET + 1'b1);
      issue_request(OP_LOOKUP, key_b, '0);
      issue_request(OP_LOOKUP, key_a, '0);
   endtask

   // Limit at zero and at its top value
   task automatic test_limit_extremes();
      write_max_length('0);
      issue_request(OP_INSERT, 64'h0123_4567_89ab_cdef, '0);
      issue_request(OP_INSERT, 64'hfedc_ba98_7654_3210, 20'd1);
      write_max_length('1);
      issue_request(OP_INSERT, '1, '1);
      issue_request(OP_LOOKUP, '1, '0);
      issue_request(OP_LOOKUP, 64'h0123_4567_89ab_cdef, '0);
   endtask

   // Equal keys coexist; lookup answers from the highest slot
   task automatic test_duplicate_keys();
      logic [REQ_KEY_BITS-1:0] dup_key;
      dup_key = {$urandom, $urandom};
      issue_request(OP_INSERT, dup_key, 20'd5);
      issue_request(OP_INSERT, dup_key, 20'd9);
      issue_request(OP_LOOKUP, dup_key, '0);
      issue_request(OP_LOOKUP, dup_key ^ 64'h1, '0);
   endtask

   // Random traffic over a small key pool so hits, misses and evictions all occur
   task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [LEN_BITS-1:0] limit, input int count);
      logic [REQ_KEY_BITS-1:0] key_pool [KEY_POOL_SIZE];
      logic [REQ_KEY_BITS-1:0] key;
      logic [LEN_BITS-1:0]     len;
      logic                    op;
      int                      pick;
      write_max_length(limit);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(99) < 45) ? OP_INSERT : OP_LOOKUP;
         pick = $urandom_range(99);
         if (pick < 80)
            key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
         else if (pick < 90)
            key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)] ^
                  (64'd1 << $urandom_range(REQ_KEY_BITS - 1));
         else
            key = {$urandom, $urandom};
         pick = $urandom_range(99);
         if (pick < 65)      len = LEN_BITS'($urandom_range(max_len_limit));
         else if (pick < 80) len = LEN_BITS'($urandom);
         else if (pick < 90) len = max_len_limit;
         else if (pick < 95) len = max_len_limit + 1'b1;
         else                len = '0;
         issue_request(op, key, len);
      end
   endtask

   initial begin
      apply_reset();
      test_empty_lookups();
      test_length_boundaries();
      test_limit_extremes();
      test_duplicate_keys();
      run_random_phase(10, 84, MAX_LEN_RESET, PHASE_REQUESTS);
      run_random_phase(84, 10, LEN_BITS'($urandom_range(20'hFFFFF)), PHASE_REQUESTS);
      run_random_phase(0, 0, '1, PHASE_REQUESTS);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d requests: %0d hits, %0d misses, %0d stores, %0d rejects",
               request_count, hit_count, miss_count, store_count, reject_count);
      $display("LRU evictions: %0d, length limit writes: %0d, errors: %0d",
               evict_count, limit_writes, error_count);
      if (error_count == 0) begin
         $display("lru_key_cache_directory_core verification clean");
      end else begin
         $display("lru_key_cache_directory_core verification failed");
      end
      $finish;
   end

endmodule
